@@ src/bcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bcmp_pkg
// Shared types, constants and helpers for the barometer compensation block.
// ----------------------------------------------------------------------------
package bcmp_pkg;

  localparam int DIV_W = 32;
  localparam int PIPE_LEN = 79;

  localparam logic [31:0] T_OFFSET   = 32'd4000;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [31:0] P_SQ_COEF  = 32'd3038;
  localparam logic [31:0] P_LIN_COEF = 32'hFFFF_E343;
  localparam logic [31:0] P_BIAS     = 32'd3791;
  localparam logic [31:0] B4_BIAS    = 32'h0000_8000;
  localparam logic [17:0] PRESS_MAX  = 18'h3FFFF;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [17:0]        pressure;
    logic               divide_fault;
  } out_word_t;

  typedef struct packed {
    logic        fault;
    logic        neg;
    logic        shl;
    logic [23:0] pval;
    logic [31:0] x1;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic [31:0] b5;
    logic [31:0] t;
    logic [31:0] b6;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [31:0] pc;
    logic [31:0] pd;
    logic [31:0] pe;
    logic [31:0] x3;
    logic [31:0] x3b;
    logic [31:0] b3;
    logic [31:0] m;
    logic [31:0] pf;
    logic [31:0] b7;
    logic [31:0] p;
    logic [31:0] ps;
    logic [31:0] px;
    logic [31:0] pt;
    logic [31:0] corr;
  } item_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] v, int n);
    return 32'($signed(v) >>> n);
  endfunction

endpackage

@@ src/barometer_compensation_top.sv @@
// ----------------------------------------------------------------------------
// barometer_compensation_top
// Pipelined; the computation includes two 32-stage dividers.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: synchronous; clears valid bits, calibration to 0, oversampling to 1.
// ----------------------------------------------------------------------------
module barometer_compensation_top
  import bcmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
  logic [1:0]  oss;
  logic [PIPE_LEN-1:0] vld;
  logic adv;
  item_t st [1:14];
  item_t nx [1:14];
  item_t dl1 [1:DIV_W];
  item_t dl2 [1:DIV_W];
  logic [31:0] q1, q2;
  out_word_t out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= '0;
      cal_ac3_ac4 <= '0;
      cal_ac5_ac6 <= '0;
      cal_b1_b2   <= '0;
      cal_mc_md   <= '0;
      oss         <= 2'd1;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_AC1_AC2: cal_ac1_ac2 <= cfg_data;
        REG_AC3_AC4: cal_ac3_ac4 <= cfg_data;
        REG_AC5_AC6: cal_ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal_b1_b2   <= cfg_data;
        REG_MC_MD:   cal_mc_md   <= cfg_data;
        REG_OSS:     oss         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !vld[PIPE_LEN-1] || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic [31:0] d;
    logic [31:0] v;
    logic [31:0] x2;
    logic [31:0] s;
    logic [31:0] b7;
    nx[1] = '0;
    d = {16'd0, in_word.raw_temperature} - {16'd0, cal_ac5_ac6[15:0]};
    nx[1].x1   = asr(d * {16'd0, cal_ac5_ac6[31:16]}, 15);
    nx[1].pval = in_word.raw_pressure >> (4'd8 - {2'b00, oss});

    nx[2] = st[1];
    d = st[1].x1 + sx16(cal_mc_md[15:0]);
    v = sx16(cal_mc_md[31:16]) << 11;
    nx[2].fault = (d == '0);
    nx[2].neg   = v[31] ^ d[31];
    nx[2].dvd   = v[31] ? -v : v;
    nx[2].dvs   = d[31] ? -d : d;

    nx[3] = dl1[DIV_W];
    x2 = dl1[DIV_W].neg ? -q1 : q1;
    nx[3].b5 = dl1[DIV_W].x1 + x2;

    nx[4] = st[3];
    nx[4].t  = asr(st[3].b5 + 32'd8, 4);
    nx[4].b6 = st[3].b5 - T_OFFSET;

    nx[5] = st[4];
    nx[5].pa = st[4].b6 * st[4].b6;
    nx[5].pb = sx16(cal_ac1_ac2[15:0]) * st[4].b6;
    nx[5].pc = sx16(cal_ac3_ac4[31:16]) * st[4].b6;

    nx[6] = st[5];
    nx[6].pd = sx16(cal_b1_b2[15:0]) * asr(st[5].pa, 12);
    nx[6].pe = sx16(cal_b1_b2[31:16]) * asr(st[5].pa, 12);

    nx[7] = st[6];
    nx[7].x3  = asr(st[6].pd, 11) + asr(st[6].pb, 11);
    nx[7].x3b = asr(asr(st[6].pc, 13) + asr(st[6].pe, 16) + 32'd2, 2);

    nx[8] = st[7];
    s = (sx16(cal_ac1_ac2[31:16]) << 2) + st[7].x3;
    nx[8].b3 = asr((s << oss) + 32'd2, 2);
    nx[8].m  = st[7].x3b + B4_BIAS;

    nx[9] = st[8];
    nx[9].pf = {16'd0, cal_ac3_ac4[15:0]} * st[8].m;
    nx[9].b7 = ({8'd0, st[8].pval} - st[8].b3) * (B7_SCALE >> oss);

    nx[10] = st[9];
    b7 = st[9].b7;
    nx[10].dvs   = st[9].pf >> 15;
    nx[10].fault = st[9].fault || (nx[10].dvs == '0);
    nx[10].shl   = (b7 < SIGN_BIT);
    nx[10].dvd   = nx[10].shl ? (b7 << 1) : b7;

    nx[11] = dl2[DIV_W];
    nx[11].p = dl2[DIV_W].shl ? q2 : (q2 << 1);

    nx[12] = st[11];
    s = st[11].p >> 8;
    nx[12].ps = s * s;
    nx[12].px = st[11].p * P_LIN_COEF;

    nx[13] = st[12];
    nx[13].pt = st[12].ps * P_SQ_COEF;

    nx[14] = st[13];
    nx[14].corr = asr(asr(st[13].pt, 16) + asr(st[13].px, 16) + P_BIAS, 4);
  end

  always_comb begin
    logic signed [33:0] pv;
    logic signed [31:0] tv;
    out_next = '0;
    tv = $signed(st[14].t);
    pv = $signed({2'b00, st[14].p}) + 34'($signed(st[14].corr));
    if (tv > 32'sd32767) begin
      out_next.temperature = 16'sh7FFF;
    end else if (tv < -32'sd32768) begin
      out_next.temperature = 16'sh8000;
    end else begin
      out_next.temperature = tv[15:0];
    end
    if (pv < 34'sd0) begin
      out_next.pressure = '0;
    end else if (pv > $signed({16'd0, PRESS_MAX})) begin
      out_next.pressure = PRESS_MAX;
    end else begin
      out_next.pressure = pv[17:0];
    end
    if (st[14].fault) begin
      out_next = '0;
      out_next.divide_fault = 1'b1;
    end
  end

  bcmp_div u_div_t (
    .clk      (clk),
    .en       (adv),
    .dividend (st[2].dvd),
    .divisor  (st[2].dvs),
    .quotient (q1)
  );

  bcmp_div u_div_p (
    .clk      (clk),
    .en       (adv),
    .dividend (st[10].dvd),
    .divisor  (st[10].dvs),
    .quotient (q2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st     <= nx;
      dl1[1] <= st[2];
      dl2[1] <= st[10];
      for (int i = 2; i <= DIV_W; i++) begin
        dl1[i] <= dl1[i-1];
        dl2[i] <= dl2[i-1];
      end
      out_word <= out_next;
    end
  end

  assign out_valid = vld[PIPE_LEN-1];

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.divide_fault |->
      out_word.temperature == 16'sd0 && out_word.pressure == 18'd0)
    else $error("fault result not zeroed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost at entry");

endmodule

@@ src/bcmp_div.sv @@
// ----------------------------------------------------------------------------
// bcmp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcmp_div
  import bcmp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] rem_q [1:DIV_W];
  logic [DIV_W-1:0] num_q [1:DIV_W];
  logic [DIV_W-1:0] dvs_q [1:DIV_W];
  logic [DIV_W-1:0] rem_next [1:DIV_W];
  logic [DIV_W-1:0] num_next [1:DIV_W];
  logic [DIV_W-1:0] dvs_next [1:DIV_W];

  always_comb begin
    logic [DIV_W-1:0] prem;
    logic [DIV_W-1:0] pnum;
    logic [DIV_W-1:0] pdvs;
    logic [DIV_W+1:0] diff;
    for (int i = 1; i <= DIV_W; i++) begin
      prem = (i == 1) ? '0 : rem_q[i-1];
      pnum = (i == 1) ? dividend : num_q[i-1];
      pdvs = (i == 1) ? divisor : dvs_q[i-1];
      diff = {1'b0, prem, pnum[DIV_W-1]} - {2'b00, pdvs};
      if (!diff[DIV_W+1]) begin
        rem_next[i] = diff[DIV_W-1:0];
        num_next[i] = {pnum[DIV_W-2:0], 1'b1};
      end else begin
        rem_next[i] = {prem[DIV_W-2:0], pnum[DIV_W-1]};
        num_next[i] = {pnum[DIV_W-2:0], 1'b0};
      end
      dvs_next[i] = pdvs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_next;
      num_q <= num_next;
      dvs_q <= dvs_next;
    end
  end

  assign quotient = num_q[DIV_W];

endmodule
